### design/rician_k_factor_accumulator_defines.svh
// assertion macros for the rician k-factor accumulator
// used by the top level only, no other dependencies
`ifndef RICIAN_K_FACTOR_ACCUMULATOR_DEFINES_SVH
`define RICIAN_K_FACTOR_ACCUMULATOR_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RKF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// implication whose consequent is checked in the next cycle
`define RKF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

### design/rkf_pkg.sv
// shared types and constants for the rician k-factor accumulator
// no dependencies
package rkf_pkg;

    localparam int COORD_BITS = 24;
    localparam int POWER_BITS = 32;
    localparam int WIN_BITS   = 20;
    localparam int LEN_BITS   = 26;
    localparam int THR_BITS   = 27;
    localparam int SUM_BITS   = 44;
    localparam int KF_BITS    = 32;
    localparam int SQ_BITS    = 64;
    localparam int ROOT_BITS  = 32;
    localparam int DIV_BITS   = SUM_BITS + 16;

    localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(10);
    localparam logic [SUM_BITS-1:0] SUM_MAX   = {SUM_BITS{1'b1}};
    localparam logic [THR_BITS-1:0] THR_MAX   = {THR_BITS{1'b1}};
    localparam logic [KF_BITS-1:0]  KF_MAX    = {KF_BITS{1'b1}};

    // controller to datapath commands
    typedef struct packed {
        logic load_in;     // capture input item
        logic sq_start;    // start one squared difference step
        logic sq_acc;      // add the squared term
        logic sqrt_start;
        logic sqrt_step;
        logic thr_load;    // threshold from root
        logic sums_clear;
        logic accum;       // add power into a sum
        logic div_start;
        logic div_step;
        logic res_load;    // finish result into output register
    } rkf_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic first;
        logic last;
        logic sqrt_done;
        logic div_done;
    } rkf_stat_t;

endpackage

### design/rkf_datapath.sv
// datapath: coordinate squares, iterative root, sums, iterative divider
// depends on rkf_pkg
module rkf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rkf_pkg::rkf_cmd_t                   cmd,
    output rkf_pkg::rkf_stat_t                  stat,
    input  logic [rkf_pkg::WIN_BITS-1:0]        window,
    input  logic                                first_path,
    input  logic                                last_path,
    input  logic                                path_present,
    input  logic signed [rkf_pkg::COORD_BITS-1:0] tx_x,
    input  logic signed [rkf_pkg::COORD_BITS-1:0] tx_y,
    input  logic signed [rkf_pkg::COORD_BITS-1:0] tx_z,
    input  logic signed [rkf_pkg::COORD_BITS-1:0] rx_x,
    input  logic signed [rkf_pkg::COORD_BITS-1:0] rx_y,
    input  logic signed [rkf_pkg::COORD_BITS-1:0] rx_z,
    input  logic [rkf_pkg::POWER_BITS-1:0]      path_power,
    input  logic [rkf_pkg::LEN_BITS-1:0]        path_len_mm,
    output logic [rkf_pkg::KF_BITS-1:0]         k_factor,
    output logic                                k_infinite,
    output logic [rkf_pkg::SUM_BITS-1:0]        total_gain
);
    import rkf_pkg::*;

    localparam int DW = COORD_BITS + 1;

    // captured item
    logic                   first_reg, last_reg, present_reg;
    logic [POWER_BITS-1:0]  power_reg;
    logic [LEN_BITS-1:0]    len_reg;
    logic [DW-1:0]          mag_reg [3];
    logic [1:0]             axis_reg;
    logic [2*DW-1:0]        prod_reg;
    logic [SQ_BITS-1:0]     sq_reg;

    // root and divider state
    logic [SQ_BITS-1:0]     rem_reg;
    logic [ROOT_BITS-1:0]   root_reg;
    logic [5:0]             sqrt_cnt_reg;
    logic [THR_BITS-1:0]    thr_reg;
    logic [SUM_BITS-1:0]    los_reg, nlos_reg;
    logic [DIV_BITS-1:0]    quo_reg;
    logic [SUM_BITS:0]      drem_reg;
    logic [5:0]             div_cnt_reg;

    logic [DW-1:0]          d_x, d_y, d_z;
    logic [DW-1:0]          mag_sel;
    logic [SQ_BITS:0]       sq_sum;
    logic [SQ_BITS-1:0]     trial;
    logic [SQ_BITS-1:0]     pair;
    logic [SUM_BITS:0]      los_add, nlos_add, tot_add, drem_sh;
    logic [THR_BITS:0]      thr_add;

    function automatic logic [DW-1:0] absdiff(logic signed [COORD_BITS-1:0] a,
                                              logic signed [COORD_BITS-1:0] b);
        logic signed [DW-1:0] d;
        d = DW'(a) - DW'(b);
        return d[DW-1] ? DW'(-d) : DW'(d);
    endfunction

    assign d_x = absdiff(tx_x, rx_x);
    assign d_y = absdiff(tx_y, rx_y);
    assign d_z = absdiff(tx_z, rx_z);
    assign mag_sel = mag_reg[axis_reg];
    assign sq_sum  = {1'b0, sq_reg} + (SQ_BITS+1)'(prod_reg);

    // root: current pair of bits and trial value
    assign pair  = rem_reg;
    assign trial = {{(SQ_BITS-ROOT_BITS-2){1'b0}}, root_reg, 2'b01};
    assign thr_add = (THR_BITS+1)'(root_reg) + (THR_BITS+1)'(window);

    assign los_add  = {1'b0, los_reg} + (SUM_BITS+1)'(power_reg);
    assign nlos_add = {1'b0, nlos_reg} + (SUM_BITS+1)'(power_reg);
    assign tot_add  = {1'b0, los_reg} + {1'b0, nlos_reg};
    assign drem_sh  = {drem_reg[SUM_BITS-1:0], quo_reg[DIV_BITS-1]};

    assign stat.first     = first_reg;
    assign stat.last      = last_reg;
    assign stat.sqrt_done = (sqrt_cnt_reg == 6'd0);
    assign stat.div_done  = (div_cnt_reg == 6'd0);

    // capture and squares
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            first_reg   <= first_path;
            last_reg    <= last_path;
            present_reg <= path_present;
            power_reg   <= path_power;
            len_reg     <= path_len_mm;
            mag_reg[0]  <= d_x;
            mag_reg[1]  <= d_y;
            mag_reg[2]  <= d_z;
            axis_reg    <= 2'd0;
            sq_reg      <= '0;
        end
        if (cmd.sq_start)
        begin
            prod_reg <= mag_sel * mag_sel;
            axis_reg <= axis_reg + 2'd1;
        end
        if (cmd.sq_acc)
            sq_reg <= sq_sum[SQ_BITS-1:0];
    end

    // root, one result bit per step, remainder held in rem, radicand shifted in
    logic [SQ_BITS-1:0] rad_reg;
    logic [SQ_BITS-1:0] r_rem;
    always_comb
    begin
        r_rem = {pair[SQ_BITS-3:0], rad_reg[SQ_BITS-1:SQ_BITS-2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg      <= '0;
            rem_reg      <= '0;
            root_reg     <= '0;
            quo_reg      <= '0;
            drem_reg     <= '0;
            sqrt_cnt_reg <= '0;
            div_cnt_reg  <= '0;
            thr_reg      <= '0;
            los_reg      <= '0;
            nlos_reg     <= '0;
        end
        else
        begin
            if (cmd.sqrt_start)
            begin
                rad_reg      <= sq_reg;
                rem_reg      <= '0;
                root_reg     <= '0;
                sqrt_cnt_reg <= 6'd32;
            end
            else if (cmd.sqrt_step)
            begin
                rad_reg      <= {rad_reg[SQ_BITS-3:0], 2'b00};
                sqrt_cnt_reg <= sqrt_cnt_reg - 6'd1;
                if (r_rem >= trial)
                begin
                    rem_reg  <= r_rem - trial;
                    root_reg <= {root_reg[ROOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= r_rem;
                    root_reg <= {root_reg[ROOT_BITS-2:0], 1'b0};
                end
            end
            if (cmd.thr_load)
                thr_reg <= (thr_add[THR_BITS] || root_reg[ROOT_BITS-1:THR_BITS] != '0)
                           ? THR_MAX : thr_add[THR_BITS-1:0];
            if (cmd.sums_clear)
            begin
                los_reg  <= '0;
                nlos_reg <= '0;
            end
            else if (cmd.accum && present_reg)
            begin
                if ((THR_BITS)'(len_reg) <= thr_reg)
                    los_reg <= los_add[SUM_BITS] ? SUM_MAX : los_add[SUM_BITS-1:0];
                else
                    nlos_reg <= nlos_add[SUM_BITS] ? SUM_MAX : nlos_add[SUM_BITS-1:0];
            end
            // restoring divider, one quotient bit per step
            if (cmd.div_start)
            begin
                quo_reg     <= {los_reg, 16'd0};
                drem_reg    <= '0;
                div_cnt_reg <= 6'(DIV_BITS);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - 6'd1;
                if (drem_sh >= {1'b0, nlos_reg})
                begin
                    drem_reg <= drem_sh - {1'b0, nlos_reg};
                    quo_reg  <= {quo_reg[DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= drem_sh;
                    quo_reg  <= {quo_reg[DIV_BITS-2:0], 1'b0};
                end
            end
            if (cmd.res_load)
            begin
                los_reg  <= '0;
                nlos_reg <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            total_gain <= tot_add[SUM_BITS] ? SUM_MAX : tot_add[SUM_BITS-1:0];
            if (nlos_reg == '0)
            begin
                k_factor   <= (los_reg != '0) ? KF_MAX : '0;
                k_infinite <= (los_reg != '0);
            end
            else
            begin
                k_factor   <= (quo_reg[DIV_BITS-1:KF_BITS] != '0) ? KF_MAX
                                                                 : quo_reg[KF_BITS-1:0];
                k_infinite <= 1'b0;
            end
        end
    end

endmodule

### design/rkf_ctrl.sv
// controller state machine sequencing the datapath
// depends on rkf_pkg
module rkf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  rkf_pkg::rkf_stat_t stat,
    output rkf_pkg::rkf_cmd_t  cmd
);
    import rkf_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SQ    = 8'b0000_0010,
        S_SQACC = 8'b0000_0100,
        S_SQRT  = 8'b0000_1000,
        S_THR   = 8'b0001_0000,
        S_ACC   = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_RES   = 8'b1000_0000
    } rkf_state_t;

    rkf_state_t state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       ov_reg, ov_next;

    // input taken when idle and no result waiting, or the waiting result is being taken
    assign in_ready  = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load_in = 1'b1;
                    axis_next   = 2'd0;
                    state_next  = S_SQ;
                end
            end
            S_SQ:
            begin
                // all three squares summed: start the root
                if (stat.first && axis_reg == 2'd3)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_SQRT;
                end
                else if (stat.first)
                begin
                    cmd.sq_start = 1'b1;
                    state_next   = S_SQACC;
                end
                else
                    state_next = S_ACC;
            end
            S_SQACC:
            begin
                cmd.sq_acc = 1'b1;
                axis_next  = axis_reg + 2'd1;
                state_next = S_SQ;
            end
            S_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.thr_load   = 1'b1;
                    cmd.sums_clear = 1'b1;
                    state_next     = S_ACC;
                end
                else
                    cmd.sqrt_step = 1'b1;
            end
            S_ACC:
            begin
                cmd.accum = 1'b1;
                if (stat.last)
                begin
                    state_next = S_THR;
                end
                else
                    state_next = S_IDLE;
            end
            S_THR:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_RES;
                else
                    cmd.div_step = 1'b1;
            end
            S_RES:
            begin
                if (!ov_reg)
                begin
                    cmd.res_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 2'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

### design/rician_k_factor_accumulator.sv
// rician k-factor accumulator top level: config register, controller, datapath
// depends on rkf_pkg, rkf_ctrl, rkf_datapath and the assertion macro header
//
// usage:
//   in_valid/in_ready carries one path transaction; first_path starts a
//   snapshot and samples positions, last_path ends it and yields one result
//   on out_valid/out_ready (k_factor, k_infinite, total_gain).
//   cfg_valid/cfg_ready writes los_window_mm (reset 10); cfg_ready is always
//   high, writes belong to idle periods.
// sequence:
//   plain path: accept, dispatch, accumulate.
//   first item adds the three squares, then the start and the steps of the
//   bit-serial root; last item adds the divider start, its 60 quotient bits
//   and done, then the result register load.
//   a new item is accepted only once the previous one is done.
// reset: sums, threshold and window return to their reset values, no result
//   is pending.
// stall: a held result blocks new input only until it is taken; the last
//   item's result waits for the output register to empty before loading.
`include "rician_k_factor_accumulator_defines.svh"
module rician_k_factor_accumulator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rkf_pkg::WIN_BITS-1:0]        los_window_mm,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                first_path,
    input  logic                                last_path,
    input  logic                                path_present,
    input  logic signed [rkf_pkg::COORD_BITS-1:0] tx_x,
    input  logic signed [rkf_pkg::COORD_BITS-1:0] tx_y,
    input  logic signed [rkf_pkg::COORD_BITS-1:0] tx_z,
    input  logic signed [rkf_pkg::COORD_BITS-1:0] rx_x,
    input  logic signed [rkf_pkg::COORD_BITS-1:0] rx_y,
    input  logic signed [rkf_pkg::COORD_BITS-1:0] rx_z,
    input  logic [rkf_pkg::POWER_BITS-1:0]      path_power,
    input  logic [rkf_pkg::LEN_BITS-1:0]        path_len_mm,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rkf_pkg::KF_BITS-1:0]         k_factor,
    output logic                                k_infinite,
    output logic [rkf_pkg::SUM_BITS-1:0]        total_gain
);
    import rkf_pkg::*;

    logic [WIN_BITS-1:0] window_reg;
    rkf_cmd_t            cmd;
    rkf_stat_t           stat;

    // window register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= WIN_RESET;
        else if (cfg_valid)
            window_reg <= los_window_mm;
    end

    rkf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rkf_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .window       (window_reg),
        .first_path   (first_path),
        .last_path    (last_path),
        .path_present (path_present),
        .tx_x         (tx_x),
        .tx_y         (tx_y),
        .tx_z         (tx_z),
        .rx_x         (rx_x),
        .rx_y         (rx_y),
        .rx_z         (rx_z),
        .path_power   (path_power),
        .path_len_mm  (path_len_mm),
        .k_factor     (k_factor),
        .k_infinite   (k_infinite),
        .total_gain   (total_gain)
    );

    // a loaded result shows valid next cycle
    `RKF_ASSERT_NEXT(a_res_valid, clk, rst_n, cmd.res_load, out_valid)
    // infinite flag only with saturated ratio
    `RKF_ASSERT_IMPL(a_inf_sat, clk, rst_n, out_valid && k_infinite, k_factor == KF_MAX)
    // no input taken while the datapath is busy with division
    `RKF_ASSERT_IMPL(a_busy, clk, rst_n, cmd.div_step, !in_ready)

endmodule
